[rtl/core/rqr_pkg.sv]
`timescale 1ns / 1ps
// package for the ready queue with removal: command and status codes,
// default slot count and the write-control group of the link/pid store
// no dependencies
package rqr_pkg;

    localparam int RQR_MAX_TASKS = 16;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_FIND   = 2'd3
    } rqr_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_QUEUED     = 2'd1,
        STAT_NOT_QUEUED = 2'd2,
        STAT_NOT_FOUND  = 2'd3
    } rqr_status_t;

    // field write enables of the store, all at one address
    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic pid_we;
    } rqr_wr_t;

endpackage

[rtl/core/rqr_store.sv]
`timescale 1ns / 1ps
// link and process-id store of the ready queue: two synchronous memories,
// one write address and one read address per cycle, registered read data
// depends on rqr_pkg
module rqr_store #(
    parameter int MAX_TASKS = rqr_pkg::RQR_MAX_TASKS
) (
    input  logic                           clk,
    input  logic [$clog2(MAX_TASKS)-1:0]   rd_addr,
    input  rqr_pkg::rqr_wr_t               wr_ctl,
    input  logic [$clog2(MAX_TASKS)-1:0]   wr_addr,
    input  logic [$clog2(MAX_TASKS)-1:0]   wr_next,
    input  logic [$clog2(MAX_TASKS)-1:0]   wr_prev,
    input  logic [31:0]                    wr_pid,
    output logic [$clog2(MAX_TASKS)-1:0]   rd_next,
    output logic [$clog2(MAX_TASKS)-1:0]   rd_prev,
    output logic [31:0]                    rd_pid
);
    import rqr_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TASKS);

    // {next, prev} per slot, each field writable on its own
    logic [2*SLOT_W-1:0] link_mem [MAX_TASKS];
    logic [31:0]         pid_mem  [MAX_TASKS];
    logic [2*SLOT_W-1:0] link_rd_reg;
    logic [31:0]         pid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.next_we)
        begin
            link_mem[wr_addr][2*SLOT_W-1:SLOT_W] <= wr_next;
        end
        if (wr_ctl.prev_we)
        begin
            link_mem[wr_addr][SLOT_W-1:0] <= wr_prev;
        end
        if (wr_ctl.pid_we)
        begin
            pid_mem[wr_addr] <= wr_pid;
        end
        link_rd_reg <= link_mem[rd_addr];
        pid_rd_reg  <= pid_mem[rd_addr];
    end

    assign rd_next = link_rd_reg[2*SLOT_W-1:SLOT_W];
    assign rd_prev = link_rd_reg[SLOT_W-1:0];
    assign rd_pid  = pid_rd_reg;

endmodule

[rtl/core/ready_queue_with_removal.sv]
`timescale 1ns / 1ps
// ready queue with removal: doubly linked fifo of task slots with current
// task tracking, idle-task fallback and search by process id
// depends on rqr_pkg and rqr_store
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_valid, req_stall | cmd, slot, pid
//  rsp     | out       | rsp_valid, rsp_stall | result_slot, result_is_idle, status,
//          |           |                      | queued_count, queue_empty
//
// one item at a time; the find walk follows one link per cycle through the
// store's single read port
// reset clears the control state and the in-queue flags at once; links and
// process ids are not cleared, they are only read for slots that were pushed
// a new item is taken while a result still waits on rsp_stall; its work
// starts once the result register is free
module ready_queue_with_removal #(
    parameter int MAX_TASKS = rqr_pkg::RQR_MAX_TASKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  cmd,
    input  logic [3:0]  slot,
    input  logic [31:0] pid,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [3:0]  result_slot,
    output logic        result_is_idle,
    output logic [1:0]  status,
    output logic [4:0]  queued_count,
    output logic        queue_empty
);
    import rqr_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PUSH_LINK,
        ST_POP_WAIT,
        ST_REM_WAIT,
        ST_REM_PREV,
        ST_FIND_CUR,
        ST_WALK
    } state_t;

    // control state
    state_t                state_reg,    state_next;
    logic [SLOT_W-1:0]     head_reg,     head_next;
    logic [SLOT_W-1:0]     tail_reg,     tail_next;
    logic [CNT_W-1:0]      count_reg,    count_next;
    logic [SLOT_W-1:0]     cur_reg,      cur_next;
    logic                  cur_idle_reg, cur_idle_next;
    logic [MAX_TASKS-1:0]  in_queue_reg, in_queue_next;
    logic [SLOT_W-1:0]     node_reg,     node_next;
    logic [CNT_W-1:0]      left_reg,     left_next;
    logic [SLOT_W-1:0]     rem_p_reg,    rem_p_next;
    logic [SLOT_W-1:0]     rem_n_reg,    rem_n_next;
    logic                  rsp_valid_reg;

    // item payload held during its work
    rqr_cmd_t              cmd_reg;
    logic [3:0]            slot_reg;
    logic [31:0]           pid_reg;

    // result register
    logic [3:0]            res_slot_reg;
    logic                  res_idle_reg;
    rqr_status_t           res_status_reg;
    logic [CNT_W-1:0]      res_count_reg;

    // store interface
    logic [SLOT_W-1:0]     rd_addr;
    rqr_wr_t               wr_ctl;
    logic [SLOT_W-1:0]     wr_addr;
    logic [SLOT_W-1:0]     wr_next;
    logic [SLOT_W-1:0]     wr_prev;
    logic [31:0]           wr_pid;
    logic [SLOT_W-1:0]     rd_next;
    logic [SLOT_W-1:0]     rd_prev;
    logic [31:0]           rd_pid;

    // result of the cycle that finishes an item
    logic                  finish;
    logic [SLOT_W-1:0]     fin_slot;
    logic                  fin_idle;
    rqr_status_t           fin_status;
    logic                  start_walk;
    logic                  end_walk;

    logic                  out_free;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     slot_idx;

    rqr_store #(
        .MAX_TASKS (MAX_TASKS)
    ) u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr_ctl  (wr_ctl),
        .wr_addr (wr_addr),
        .wr_next (wr_next),
        .wr_prev (wr_prev),
        .wr_pid  (wr_pid),
        .rd_next (rd_next),
        .rd_prev (rd_prev),
        .rd_pid  (rd_pid)
    );

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign slot_ok   = int'(slot_reg) < MAX_TASKS;
    assign slot_idx  = SLOT_W'(slot_reg);
    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        cur_idle_next = cur_idle_reg;
        in_queue_next = in_queue_reg;
        node_next     = node_reg;
        left_next     = left_reg;
        rem_p_next    = rem_p_reg;
        rem_n_next    = rem_n_reg;
        finish        = 1'b0;
        fin_slot      = '0;
        fin_idle      = 1'b0;
        fin_status    = STAT_OK;
        start_walk    = 1'b0;
        end_walk      = 1'b0;
        rd_addr       = head_reg;
        wr_ctl        = '0;
        wr_addr       = slot_idx;
        wr_next       = '0;
        wr_prev       = tail_reg;
        wr_pid        = pid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // wait here until the last result has been taken
                if (out_free)
                begin
                    case (cmd_reg)
                        CMD_PUSH:
                        begin
                            if (!slot_ok)
                            begin
                                finish     = 1'b1;
                                fin_status = STAT_NOT_QUEUED;
                            end
                            else if (in_queue_reg[slot_idx])
                            begin
                                finish     = 1'b1;
                                fin_status = STAT_QUEUED;
                            end
                            else
                            begin
                                // new entry: no successor, tail as predecessor
                                wr_ctl                  = '{next_we: 1'b1, prev_we: 1'b1,
                                                            pid_we: 1'b1};
                                in_queue_next[slot_idx] = 1'b1;
                                count_next              = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    head_next = slot_idx;
                                    tail_next = slot_idx;
                                    finish    = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_PUSH_LINK;
                                end
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                cur_idle_next = 1'b1;
                                finish        = 1'b1;
                                fin_idle      = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                state_next = ST_POP_WAIT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!slot_ok || !in_queue_reg[slot_idx])
                            begin
                                finish     = 1'b1;
                                fin_status = STAT_NOT_QUEUED;
                            end
                            else
                            begin
                                rd_addr    = slot_idx;
                                state_next = ST_REM_WAIT;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (!cur_idle_reg)
                            begin
                                rd_addr    = cur_reg;
                                state_next = ST_FIND_CUR;
                            end
                            else if (pid_reg == '0)
                            begin
                                finish   = 1'b1;
                                fin_idle = 1'b1;
                            end
                            else
                            begin
                                start_walk = 1'b1;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_PUSH_LINK:
            begin
                // old tail points forward to the new entry
                wr_ctl.next_we = 1'b1;
                wr_addr        = tail_reg;
                wr_next        = slot_idx;
                tail_next      = slot_idx;
                finish         = 1'b1;
            end
            ST_POP_WAIT:
            begin
                in_queue_next[head_reg] = 1'b0;
                count_next              = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    head_next = rd_next;
                end
                cur_next      = head_reg;
                cur_idle_next = 1'b0;
                finish        = 1'b1;
                fin_slot      = head_reg;
            end
            ST_REM_WAIT:
            begin
                rem_p_next              = rd_prev;
                rem_n_next              = rd_next;
                in_queue_next[slot_idx] = 1'b0;
                count_next              = count_reg - CNT_W'(1);
                if (slot_idx == head_reg)
                begin
                    head_next = rd_next;
                end
                else
                begin
                    wr_ctl.next_we = 1'b1;
                    wr_addr        = rd_prev;
                    wr_next        = rd_next;
                end
                if (slot_idx == tail_reg)
                begin
                    tail_next = rd_prev;
                    finish    = 1'b1;
                end
                else
                begin
                    state_next = ST_REM_PREV;
                end
                if (count_reg == CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
            end
            ST_REM_PREV:
            begin
                wr_ctl.prev_we = 1'b1;
                wr_addr        = rem_n_reg;
                wr_prev        = rem_p_reg;
                finish         = 1'b1;
            end
            ST_FIND_CUR:
            begin
                if (rd_pid == pid_reg)
                begin
                    finish   = 1'b1;
                    fin_slot = cur_reg;
                end
                else
                begin
                    start_walk = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (rd_pid == pid_reg)
                begin
                    finish   = 1'b1;
                    fin_slot = node_reg;
                end
                else if (left_reg == CNT_W'(1))
                begin
                    end_walk = 1'b1;
                end
                else
                begin
                    node_next = rd_next;
                    left_next = left_reg - CNT_W'(1);
                    rd_addr   = rd_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // walk the queue from its head, one link per cycle
        if (start_walk)
        begin
            if (count_reg == '0)
            begin
                end_walk = 1'b1;
            end
            else
            begin
                node_next  = head_reg;
                left_next  = count_reg;
                rd_addr    = head_reg;
                state_next = ST_WALK;
            end
        end

        // nothing matched: id zero names the idle task
        if (end_walk)
        begin
            finish = 1'b1;
            if (pid_reg == '0)
            begin
                fin_idle = 1'b1;
            end
            else
            begin
                fin_status = STAT_NOT_FOUND;
            end
        end

        if (finish)
        begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_idle_reg  <= 1'b1;
            in_queue_reg  <= '0;
            node_reg      <= '0;
            left_reg      <= '0;
            rem_p_reg     <= '0;
            rem_n_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            cur_idle_reg <= cur_idle_next;
            in_queue_reg <= in_queue_next;
            node_reg     <= node_next;
            left_reg     <= left_next;
            rem_p_reg    <= rem_p_next;
            rem_n_reg    <= rem_n_next;
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            cmd_reg  <= rqr_cmd_t'(cmd);
            slot_reg <= slot;
            pid_reg  <= pid;
        end
        if (finish)
        begin
            res_slot_reg   <= 4'(fin_slot);
            res_idle_reg   <= fin_idle;
            res_status_reg <= fin_status;
            res_count_reg  <= count_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign result_slot    = res_slot_reg;
    assign result_is_idle = res_idle_reg;
    assign status         = res_status_reg;
    assign queued_count   = 5'(res_count_reg);
    assign queue_empty    = (res_count_reg == '0);

    // entry count always matches the in-queue flags
    a_count_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(in_queue_reg)))
        else $error("entry count differs from in-queue flags");

    // empty queue parks head and tail at zero
    a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty queue with nonzero head or tail");

    // head and tail of a nonempty queue are queued slots
    a_ends_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (in_queue_reg[head_reg] && in_queue_reg[tail_reg]))
        else $error("head or tail not marked in queue");

    // a result is only produced when the result register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> out_free)
        else $error("result register overwritten");

endmodule
